FILE: sv/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/nfha_pkg.sv
`default_nettype none
package nfha_pkg;
  localparam int HEAP_BYTES = 16384;
  localparam int GROW_CHUNK = 1 * (1 << 10);
  localparam int MIN_SPLIT  = 16;
  localparam int WORD_BYTES = 8;
  localparam int HDR_WORDS  = HEAP_BYTES / 8;
  localparam int IDX_W      = $clog2(HDR_WORDS);
  localparam int TOP_W      = $clog2(HEAP_BYTES) + 1;
  localparam int OFF_W      = ((TOP_W > 16) ? TOP_W : 16) + 2;
  localparam int HDR_W      = 16;
  localparam int A_W        = 16;
  localparam int FREE_W     = 15;
  localparam int FREE_MAX   = 32767;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_RES_NONE, OP_RES_OOM,
    OP_F_START, OP_F_FIRST, OP_F_ACC, OP_F_END,
    OP_INIT_W0, OP_INIT_W1,
    OP_S1_START, OP_S2_START, OP_ADV, OP_TAKE0,
    OP_SPLIT_W0, OP_SPLIT_W1, OP_TAKE_W,
    OP_M_START, OP_M_OPEN, OP_M_ACC, OP_M_CLOSE_ADV, OP_M_CLOSE_FIN, OP_M_FIN,
    OP_G_W0, OP_G_W1
  } nfha_op_t;

  typedef struct packed {
    logic is_free;
    logic uninit;
    logic free_bad;
    logic cur_lt_top;
    logic cur_lt_rover;
    logic a_lt_free;
    logic hdr_busy;
    logic fits;
    logic split_ok;
    logic region_oom;
    logic grow_oom;
    logic coal;
  } nfha_stat_t;
endpackage
`default_nettype wire

FILE: sv/next_fit_heap_allocator.sv
// Channel   | Ports                                     | Handshake
// ----------+-------------------------------------------+--------------------------------
// input     | in_cmd, in_req_size, in_free_addr         | taken when start && !busy
// result    | out_block_addr, out_status                | out_valid high for one cycle
//
// Every item is worked on alone; busy stays high from the cycle after start and drops
// again in the cycle that shows the result. A header visited by a free walk passes a
// read state, which addresses the header store, and an evaluate state on its registered
// read data; a header visited by a search or merge walk passes an end-bound check first.
// An ignored free ends in the dispatch state, any other free walks the blocks it absorbs,
// the first allocate lays out the heap directly, and a later allocate walks the heap for
// each search and for the one merge pass.
// Reset clears the control registers synchronously; the header store is not cleared.
// The receiver cannot stall: each result is shown exactly once.
`default_nettype none
`include "assert_macros.svh"
module next_fit_heap_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [14:0] in_req_size,
  input  wire logic [13:0] in_free_addr,
  output logic             out_valid,
  output logic [13:0]      out_block_addr,
  output logic             out_status
);
  import nfha_pkg::*;

  // Command from the controller to the datapath, and status back.
  nfha_op_t   op;
  nfha_stat_t stat;

  // The controller sequences header walks; it owns no payload state.
  nfha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The datapath holds the header store, the heap pointers and the result registers.
  nfha_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .in_cmd         (in_cmd),
    .in_req_size    (in_req_size),
    .in_free_addr   (in_free_addr),
    .stat           (stat),
    .out_block_addr (out_block_addr),
    .out_status     (out_status)
  );

  // An accepted item keeps the block busy in the following cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // A result only follows a busy cycle.
  `ASSERT_NEXT(a_result_after_busy, clk, rst_n, !busy, !out_valid)
  // An out-of-memory result carries a zero address.
  `ASSERT_IMPL(a_oom_zero_addr, clk, rst_n, out_valid && out_status, out_block_addr == 14'd0)
endmodule
`default_nettype wire

FILE: sv/nfha_ctrl.sv
`default_nettype none
module nfha_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire nfha_pkg::nfha_stat_t stat,
  output nfha_pkg::nfha_op_t     op,
  output logic                   busy,
  output logic                   out_valid
);
  import nfha_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_F_RD0, ST_F_SUM0, ST_F_RD, ST_F_EV,
    ST_INIT, ST_INIT2, ST_LOOP,
    ST_S1_CHK, ST_S1_RD, ST_S1_EV, ST_S2_CHK, ST_S2_RD, ST_S2_EV,
    ST_MISS, ST_TAKE, ST_SPLIT2,
    ST_M_CHK, ST_M_RD, ST_M_EV, ST_M_TCHK, ST_M_TRD, ST_M_TEV,
    ST_GROW, ST_GROW2
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   done;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op        = OP_LATCH;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.is_free) begin
          if (stat.free_bad) begin
            op   = OP_RES_NONE;
            done = 1'b1;
          end else begin
            op        = OP_F_START;
            state_nxt = ST_F_RD0;
          end
        end else if (stat.uninit) begin
          state_nxt = ST_INIT;
        end else begin
          state_nxt = ST_LOOP;
        end
      end
      ST_F_RD0: state_nxt = ST_F_SUM0;
      ST_F_SUM0: begin
        op        = OP_F_FIRST;
        state_nxt = ST_F_RD;
      end
      ST_F_RD: state_nxt = ST_F_EV;
      ST_F_EV: begin
        if (stat.cur_lt_top && !stat.hdr_busy) begin
          op        = OP_F_ACC;
          state_nxt = ST_F_RD;
        end else begin
          op   = OP_F_END;
          done = 1'b1;
        end
      end
      ST_INIT: begin
        if (stat.region_oom) begin
          op   = OP_RES_OOM;
          done = 1'b1;
        end else begin
          op        = OP_INIT_W0;
          state_nxt = ST_INIT2;
        end
      end
      ST_INIT2: begin
        op   = OP_INIT_W1;
        done = 1'b1;
      end
      ST_LOOP: begin
        if (stat.a_lt_free) begin
          op        = OP_S1_START;
          state_nxt = ST_S1_CHK;
        end else begin
          state_nxt = ST_GROW;
        end
      end
      ST_S1_CHK: begin
        if (stat.cur_lt_top) begin
          state_nxt = ST_S1_RD;
        end else begin
          op        = OP_S2_START;
          state_nxt = ST_S2_CHK;
        end
      end
      ST_S1_RD: state_nxt = ST_S1_EV;
      ST_S1_EV: begin
        if (stat.fits) begin
          op        = OP_TAKE0;
          state_nxt = ST_TAKE;
        end else begin
          op        = OP_ADV;
          state_nxt = ST_S1_CHK;
        end
      end
      ST_S2_CHK: begin
        if (stat.cur_lt_top && stat.cur_lt_rover) begin
          state_nxt = ST_S2_RD;
        end else begin
          state_nxt = ST_MISS;
        end
      end
      ST_S2_RD: state_nxt = ST_S2_EV;
      ST_S2_EV: begin
        if (stat.fits) begin
          op        = OP_TAKE0;
          state_nxt = ST_TAKE;
        end else begin
          op        = OP_ADV;
          state_nxt = ST_S2_CHK;
        end
      end
      ST_MISS: begin
        if (stat.coal) begin
          op        = OP_M_START;
          state_nxt = ST_M_CHK;
        end else begin
          state_nxt = ST_GROW;
        end
      end
      ST_TAKE: begin
        if (stat.split_ok) begin
          op        = OP_SPLIT_W0;
          state_nxt = ST_SPLIT2;
        end else begin
          op   = OP_TAKE_W;
          done = 1'b1;
        end
      end
      ST_SPLIT2: begin
        op   = OP_SPLIT_W1;
        done = 1'b1;
      end
      ST_M_CHK: begin
        if (stat.cur_lt_top) begin
          state_nxt = ST_M_RD;
        end else begin
          op        = OP_M_FIN;
          state_nxt = ST_LOOP;
        end
      end
      ST_M_RD: state_nxt = ST_M_EV;
      ST_M_EV: begin
        if (!stat.hdr_busy) begin
          op        = OP_M_OPEN;
          state_nxt = ST_M_TCHK;
        end else begin
          op        = OP_ADV;
          state_nxt = ST_M_CHK;
        end
      end
      ST_M_TCHK: begin
        if (stat.cur_lt_top) begin
          state_nxt = ST_M_TRD;
        end else begin
          op        = OP_M_CLOSE_FIN;
          state_nxt = ST_LOOP;
        end
      end
      ST_M_TRD: state_nxt = ST_M_TEV;
      ST_M_TEV: begin
        if (!stat.hdr_busy) begin
          op        = OP_M_ACC;
          state_nxt = ST_M_TCHK;
        end else begin
          op        = OP_M_CLOSE_ADV;
          state_nxt = ST_M_CHK;
        end
      end
      ST_GROW: begin
        if (stat.grow_oom) begin
          op   = OP_RES_OOM;
          done = 1'b1;
        end else begin
          op        = OP_G_W0;
          state_nxt = ST_GROW2;
        end
      end
      ST_GROW2: begin
        op   = OP_G_W1;
        done = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (done) begin
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= done;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

FILE: sv/nfha_datapath.sv
`default_nettype none
module nfha_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire nfha_pkg::nfha_op_t   op,
  input  wire logic                 in_cmd,
  input  wire logic [14:0]          in_req_size,
  input  wire logic [13:0]          in_free_addr,
  output nfha_pkg::nfha_stat_t      stat,
  output logic [13:0]               out_block_addr,
  output logic                      out_status
);
  import nfha_pkg::*;

  // Header store, reset value undefined until written.
  logic [HDR_W-1:0] mem [HDR_WORDS];

  logic [HDR_W-1:0] rd_r;
  logic             rd_ok_r;

  logic             cmd_r, cmd_nxt;
  logic [A_W-1:0]   a_r, a_nxt;
  logic [13:0]      addr_r, addr_nxt;
  logic [TOP_W-1:0] top_r, top_nxt;
  logic [OFF_W-1:0] rover_r, rover_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic             coal_r, coal_nxt;
  logic             uninit_r, uninit_nxt;
  logic [OFF_W-1:0] cur_r, cur_nxt;
  logic [OFF_W-1:0] h_r, h_nxt;
  logic [HDR_W-1:0] p_r, p_nxt;
  logic [HDR_W-1:0] sum_r, sum_nxt;
  logic             merged_r, merged_nxt;
  logic [FREE_W-1:0] fb_r, fb_nxt;
  logic [13:0]      res_addr_r, res_addr_nxt;
  logic             res_oom_r, res_oom_nxt;

  logic             we;
  logic [OFF_W-1:0] wr_off;
  logic [HDR_W-1:0] wr_val;
  logic             wr_busy;

  logic [HDR_W-1:0] rd_data;
  logic [HDR_W-1:0] pay;
  logic [OFF_W-1:0] next_off;
  logic [OFF_W-1:0] top_ext;
  logic [OFF_W:0]   region;
  logic [A_W:0]     init_fb;
  logic [OFF_W:0]   grow_end;
  logic [13:0]      free_h;
  logic             big;

  function automatic logic [FREE_W-1:0] sat_free(input logic [OFF_W+1:0] v);
    if (v > (OFF_W+2)'(FREE_MAX)) begin
      return FREE_W'(FREE_MAX);
    end
    return v[FREE_W-1:0];
  endfunction

  assign rd_data  = rd_ok_r ? rd_r : '0;
  assign pay      = {rd_data[HDR_W-1:3], 3'b000};
  assign next_off = cur_r + OFF_W'(pay) + OFF_W'(WORD_BYTES);
  assign top_ext  = OFF_W'(top_r);
  assign big      = (a_r >= A_W'(GROW_CHUNK));
  assign region   = big ? (((OFF_W+1)'(a_r) << 1) + (OFF_W+1)'(2 * WORD_BYTES))
                        : (OFF_W+1)'(GROW_CHUNK + 2 * WORD_BYTES);
  assign init_fb  = big ? (A_W+1)'(a_r) : ((A_W+1)'(GROW_CHUNK) - (A_W+1)'(a_r));
  assign grow_end = (OFF_W+1)'(top_r) + (OFF_W+1)'(a_r)
                  + (OFF_W+1)'(2 * WORD_BYTES + GROW_CHUNK);
  assign free_h   = addr_r - 14'(WORD_BYTES);

  always_comb begin
    stat.is_free      = (cmd_r == CMD_FREE);
    stat.uninit       = uninit_r;
    stat.free_bad     = uninit_r || (addr_r < 14'(WORD_BYTES)) || (addr_r[2:0] != 3'b000)
                     || (OFF_W'(free_h) >= top_ext);
    stat.cur_lt_top   = (cur_r < top_ext);
    stat.cur_lt_rover = (cur_r < rover_r);
    stat.a_lt_free    = (a_r < A_W'(free_r));
    stat.hdr_busy     = rd_data[0];
    stat.fits         = !rd_data[0] && (pay >= a_r);
    stat.split_ok     = ((A_W+1)'(p_r) >= ((A_W+1)'(a_r) + (A_W+1)'(2 * WORD_BYTES + MIN_SPLIT)));
    stat.region_oom   = (region > (OFF_W+1)'(HEAP_BYTES));
    stat.grow_oom     = (grow_end > (OFF_W+1)'(HEAP_BYTES));
    stat.coal         = coal_r;
  end

  always_comb begin
    cmd_nxt      = cmd_r;
    a_nxt        = a_r;
    addr_nxt     = addr_r;
    top_nxt      = top_r;
    rover_nxt    = rover_r;
    free_nxt     = free_r;
    coal_nxt     = coal_r;
    uninit_nxt   = uninit_r;
    cur_nxt      = cur_r;
    h_nxt        = h_r;
    p_nxt        = p_r;
    sum_nxt      = sum_r;
    merged_nxt   = merged_r;
    fb_nxt       = fb_r;
    res_addr_nxt = res_addr_r;
    res_oom_nxt  = res_oom_r;
    we           = 1'b0;
    wr_off       = h_r;
    wr_val       = sum_r;
    wr_busy      = 1'b0;
    case (op)
      OP_LATCH: begin
        cmd_nxt  = in_cmd;
        a_nxt    = A_W'({in_req_size[14:3], 3'b000}) + A_W'(WORD_BYTES);
        addr_nxt = in_free_addr;
      end
      OP_RES_NONE: begin
        res_addr_nxt = '0;
        res_oom_nxt  = 1'b0;
      end
      OP_RES_OOM: begin
        res_addr_nxt = '0;
        res_oom_nxt  = 1'b1;
      end
      OP_F_START: begin
        cur_nxt = OFF_W'(free_h);
        h_nxt   = OFF_W'(free_h);
      end
      OP_F_FIRST: begin
        sum_nxt = pay;
        fb_nxt  = sat_free((OFF_W+2)'(free_r) + (OFF_W+2)'(pay));
        cur_nxt = next_off;
      end
      OP_F_ACC: begin
        sum_nxt = sum_r + pay + HDR_W'(WORD_BYTES);
        fb_nxt  = sat_free((OFF_W+2)'(fb_r) + (OFF_W+2)'(WORD_BYTES));
        cur_nxt = next_off;
      end
      OP_F_END: begin
        free_nxt     = fb_r;
        we           = 1'b1;
        wr_off       = h_r;
        wr_val       = sum_r;
        res_addr_nxt = '0;
        res_oom_nxt  = 1'b0;
      end
      OP_INIT_W0: begin
        uninit_nxt = 1'b0;
        top_nxt    = region[TOP_W-1:0];
        rover_nxt  = OFF_W'(a_r) + OFF_W'(WORD_BYTES);
        free_nxt   = sat_free((OFF_W+2)'(init_fb));
        we         = 1'b1;
        wr_off     = '0;
        wr_val     = a_r;
        wr_busy    = 1'b1;
      end
      OP_INIT_W1: begin
        we           = 1'b1;
        wr_off       = rover_r;
        wr_val       = init_fb[HDR_W-1:0];
        res_addr_nxt = 14'(WORD_BYTES);
        res_oom_nxt  = 1'b0;
      end
      OP_S1_START: cur_nxt = rover_r;
      OP_S2_START: cur_nxt = '0;
      OP_ADV:      cur_nxt = next_off;
      OP_TAKE0: begin
        h_nxt = cur_r;
        p_nxt = pay;
      end
      OP_SPLIT_W0: begin
        we        = 1'b1;
        wr_off    = h_r;
        wr_val    = a_r;
        wr_busy   = 1'b1;
        free_nxt  = ((A_W+1)'(free_r) > ((A_W+1)'(a_r) + (A_W+1)'(WORD_BYTES)))
                  ? FREE_W'((A_W+1)'(free_r) - (A_W+1)'(a_r) - (A_W+1)'(WORD_BYTES))
                  : '0;
        rover_nxt = h_r + OFF_W'(a_r) + OFF_W'(WORD_BYTES);
        coal_nxt  = 1'b1;
      end
      OP_SPLIT_W1: begin
        we           = 1'b1;
        wr_off       = h_r + OFF_W'(a_r) + OFF_W'(WORD_BYTES);
        wr_val       = p_r - a_r - HDR_W'(WORD_BYTES);
        res_addr_nxt = 14'(h_r + OFF_W'(WORD_BYTES));
        res_oom_nxt  = 1'b0;
      end
      OP_TAKE_W: begin
        we           = 1'b1;
        wr_off       = h_r;
        wr_val       = p_r;
        wr_busy      = 1'b1;
        rover_nxt    = h_r + OFF_W'(p_r) + OFF_W'(WORD_BYTES);
        coal_nxt     = 1'b1;
        res_addr_nxt = 14'(h_r + OFF_W'(WORD_BYTES));
        res_oom_nxt  = 1'b0;
      end
      OP_M_START: cur_nxt = '0;
      OP_M_OPEN: begin
        h_nxt      = cur_r;
        sum_nxt    = pay;
        merged_nxt = 1'b0;
        cur_nxt    = next_off;
      end
      OP_M_ACC: begin
        sum_nxt    = sum_r + pay + HDR_W'(WORD_BYTES);
        merged_nxt = 1'b1;
        cur_nxt    = next_off;
      end
      OP_M_CLOSE_ADV: begin
        // The busy block that ended the run is stepped over as well.
        we      = merged_r;
        wr_off  = h_r;
        wr_val  = sum_r;
        cur_nxt = next_off;
      end
      OP_M_CLOSE_FIN: begin
        we        = merged_r;
        wr_off    = h_r;
        wr_val    = sum_r;
        rover_nxt = top_ext;
        coal_nxt  = 1'b0;
      end
      OP_M_FIN: begin
        rover_nxt = top_ext;
        coal_nxt  = 1'b0;
      end
      OP_G_W0: begin
        we        = 1'b1;
        wr_off    = top_ext;
        wr_val    = a_r;
        wr_busy   = 1'b1;
        h_nxt     = top_ext;
        rover_nxt = top_ext + OFF_W'(a_r) + OFF_W'(WORD_BYTES);
        top_nxt   = grow_end[TOP_W-1:0];
        free_nxt  = sat_free((OFF_W+2)'(free_r) + (OFF_W+2)'(GROW_CHUNK));
      end
      OP_G_W1: begin
        we           = 1'b1;
        wr_off       = rover_r;
        wr_val       = HDR_W'(GROW_CHUNK);
        res_addr_nxt = 14'(h_r + OFF_W'(WORD_BYTES));
        res_oom_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we && (wr_off[OFF_W-1:3] < (OFF_W-3)'(HDR_WORDS))) begin
      mem[wr_off[IDX_W+2:3]] <= {wr_val[HDR_W-1:3], 2'b00, wr_busy};
    end
    rd_r    <= mem[cur_r[IDX_W+2:3]];
    rd_ok_r <= (cur_r[OFF_W-1:3] < (OFF_W-3)'(HDR_WORDS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r    <= '0;
      rover_r  <= '0;
      free_r   <= '0;
      coal_r   <= 1'b1;
      uninit_r <= 1'b1;
    end else begin
      top_r    <= top_nxt;
      rover_r  <= rover_nxt;
      free_r   <= free_nxt;
      coal_r   <= coal_nxt;
      uninit_r <= uninit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    a_r        <= a_nxt;
    addr_r     <= addr_nxt;
    cur_r      <= cur_nxt;
    h_r        <= h_nxt;
    p_r        <= p_nxt;
    sum_r      <= sum_nxt;
    merged_r   <= merged_nxt;
    fb_r       <= fb_nxt;
    res_addr_r <= res_addr_nxt;
    res_oom_r  <= res_oom_nxt;
  end

  assign out_block_addr = res_addr_r;
  assign out_status     = res_oom_r;
endmodule
`default_nettype wire

FILE: bench/next_fit_heap_allocator_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module next_fit_heap_allocator_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        in_cmd,
  input  wire logic [14:0] in_req_size,
  input  wire logic [13:0] in_free_addr,
  input  wire logic        out_valid,
  input  wire logic [13:0] out_block_addr,
  input  wire logic        out_status,
  output int               errors,
  output int               pending
);
  import nfha_pkg::*;

  typedef struct packed {
    logic [13:0] block_addr;
    logic        status;
  } alloc_result_t;

  // Shadow copy of the allocator state.
  logic [15:0]   hdr_mem [HDR_WORDS];
  int unsigned   brk_top;
  int unsigned   next_pos;
  int unsigned   spare_bytes;
  bit            may_merge;
  bit            fresh;
  alloc_result_t result_q[$];

  function automatic int unsigned hdr_get(int unsigned off);
    return ((off >> 3) < HDR_WORDS) ? int'(hdr_mem[off >> 3]) : 0;
  endfunction

  function automatic void hdr_put(int unsigned off, int unsigned size, bit used);
    if ((off >> 3) < HDR_WORDS)
      hdr_mem[off >> 3] = 16'((size & 16'hFFF8) | used);
  endfunction

  function automatic int unsigned size_of(int unsigned off);
    return hdr_get(off) & 16'hFFF8;
  endfunction

  function automatic bit used_of(int unsigned off);
    return hdr_get(off) & 1;
  endfunction

  function automatic int unsigned step_over(int unsigned off);
    return off + size_of(off) + WORD_BYTES;
  endfunction

  function automatic void put_spare(int unsigned v);
    spare_bytes = (v > FREE_MAX) ? FREE_MAX : v;
  endfunction

  function automatic bit block_fits(int unsigned off, int unsigned a);
    return !used_of(off) && size_of(off) >= a;
  endfunction

  // Next-fit walk: from the rover to the top, then from the start up to the rover.
  function automatic bit find_block(int unsigned a, output int unsigned hit);
    int unsigned cur;
    for (cur = next_pos; cur < brk_top; cur = step_over(cur))
      if (block_fits(cur, a)) begin
        hit = cur;
        return 1;
      end
    for (cur = 0; cur < next_pos && cur < brk_top; cur = step_over(cur))
      if (block_fits(cur, a)) begin
        hit = cur;
        return 1;
      end
    hit = 0;
    return 0;
  endfunction

  function automatic void claim_block(int unsigned h, int unsigned a);
    int unsigned p;
    p = size_of(h);
    if (p >= a + 2 * WORD_BYTES + MIN_SPLIT) begin
      hdr_put(h, a, 1);
      hdr_put(h + WORD_BYTES + a, p - a - WORD_BYTES, 0);
      put_spare(spare_bytes > a + WORD_BYTES ? spare_bytes - a - WORD_BYTES : 0);
    end else begin
      hdr_put(h, p, 1);
    end
    next_pos = step_over(h);
  endfunction

  function automatic void coalesce_heap();
    int unsigned cur, first, sum, t;
    cur = 0;
    while (cur < brk_top) begin
      if (!used_of(cur)) begin
        first = size_of(cur);
        sum = first;
        t = step_over(cur);
        while (t < brk_top && !used_of(t)) begin
          sum += size_of(t) + WORD_BYTES;
          t = step_over(t);
        end
        if (sum != first) hdr_put(cur, sum, 0);
        cur = t;
        if (cur >= brk_top) break;
      end
      cur = step_over(cur);
    end
    next_pos = brk_top;
  endfunction

  function automatic void release_block(int unsigned addr);
    int unsigned h, sum, cur, fb;
    if (fresh || addr < WORD_BYTES || (addr & 7) != 0) return;
    h = addr - WORD_BYTES;
    if (h >= brk_top) return;
    sum = size_of(h);
    fb = spare_bytes + sum;
    for (cur = step_over(h); cur < brk_top && !used_of(cur); cur = step_over(cur)) begin
      sum += size_of(cur) + WORD_BYTES;
      fb += WORD_BYTES;
    end
    put_spare(fb);
    hdr_put(h, sum, 0);
  endfunction

  function automatic alloc_result_t heap_response(logic cmd, int unsigned s, int unsigned fa);
    alloc_result_t r;
    int unsigned a, h, region, fb;
    r = '0;
    if (cmd == CMD_FREE) begin
      release_block(fa);
      return r;
    end
    a = (s & 32'hFFFF_FFF8) + WORD_BYTES;
    if (fresh) begin
      // The first allocate lays out the whole initial heap.
      region = (a >= GROW_CHUNK) ? 2 * a + 2 * WORD_BYTES : GROW_CHUNK + 2 * WORD_BYTES;
      fb = (a >= GROW_CHUNK) ? a : GROW_CHUNK - a;
      if (region > HEAP_BYTES) begin
        r.status = 1'b1;
        return r;
      end
      fresh = 0;
      brk_top = region;
      hdr_put(0, a, 1);
      next_pos = WORD_BYTES + a;
      hdr_put(next_pos, fb, 0);
      put_spare(fb);
      r.block_addr = 14'(WORD_BYTES);
      return r;
    end
    while (a < spare_bytes) begin
      if (find_block(a, h)) begin
        claim_block(h, a);
        may_merge = 1;
        r.block_addr = 14'(h + WORD_BYTES);
        return r;
      end else if (may_merge) begin
        coalesce_heap();
        may_merge = 0;
      end else begin
        break;
      end
    end
    if (brk_top + a + 2 * WORD_BYTES + GROW_CHUNK > HEAP_BYTES) begin
      r.status = 1'b1;
      return r;
    end
    h = brk_top;
    hdr_put(h, a, 1);
    next_pos = h + WORD_BYTES + a;
    hdr_put(next_pos, GROW_CHUNK, 0);
    brk_top = h + a + 2 * WORD_BYTES + GROW_CHUNK;
    put_spare(spare_bytes + GROW_CHUNK);
    r.block_addr = 14'(h + WORD_BYTES);
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      foreach (hdr_mem[i]) hdr_mem[i] = '0;
      brk_top = 0;
      next_pos = 0;
      spare_bytes = 0;
      may_merge = 1;
      fresh = 1;
      errors = 0;
      result_q.delete();
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with none expected: addr %0d status %0d",
                   $time, out_block_addr, out_status);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_block_addr !== want.block_addr) begin
            $display("%0t: block_addr expected %0d actual %0d",
                     $time, want.block_addr, out_block_addr);
            errors++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_status);
            errors++;
          end
        end
      end
      if (start && !busy)
        result_q.push_back(heap_response(in_cmd, 32'(in_req_size), 32'(in_free_addr)));
    end
  end

endmodule
`default_nettype wire

FILE: bench/next_fit_heap_allocator_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module next_fit_heap_allocator_tb;
  import nfha_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [14:0] in_req_size;
  logic [13:0] in_free_addr;
  logic        out_valid;
  logic [13:0] out_block_addr;
  logic        out_status;
  int          errors;
  int          pending;

  // Addresses handed out by the allocator. Live ones have not been freed by the
  // stimulus yet; retired ones have, and freeing them again exercises double frees
  // and frees of blocks that a later merge has absorbed. Every such address was a
  // real block header once, so no never-written header entry is ever read.
  int unsigned live_addrs[$];
  int unsigned retired_addrs[$];
  int          idle_pct;

  next_fit_heap_allocator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_req_size   (in_req_size),
    .in_free_addr  (in_free_addr),
    .out_valid     (out_valid),
    .out_block_addr(out_block_addr),
    .out_status    (out_status)
  );

  next_fit_heap_allocator_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_req_size   (in_req_size),
    .in_free_addr  (in_free_addr),
    .out_valid     (out_valid),
    .out_block_addr(out_block_addr),
    .out_status    (out_status),
    .errors        (errors),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Every successful allocate result goes into the pool of freeable blocks.
  // A free always returns address zero, so it never enters the pool.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_status && out_block_addr != 0)
      live_addrs.push_back(32'(out_block_addr));
  end

  // Present one item and hold it until the allocator takes it. The task returns
  // at the edge of acceptance with start still high, so a back-to-back item
  // never lowers and raises start within one time step.
  task automatic send_item(logic cmd, logic [14:0] size, logic [13:0] addr);
    in_cmd       <= cmd;
    in_req_size  <= size;
    in_free_addr <= addr;
    start        <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  // Drop start for a random stretch with the given chance; this puts gaps on
  // every phase of the allocator's work, including while it is busy.
  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Step at least one edge first so that the checker has counted the item just taken.
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic free_live();
    int unsigned k;
    k = $urandom_range(live_addrs.size() - 1);
    send_item(CMD_FREE, 15'($urandom), 14'(live_addrs[k]));
    retired_addrs.push_back(live_addrs[k]);
    live_addrs.delete(k);
  endtask

  // Mostly small requests so that the heap holds many blocks and the search,
  // split and merge paths are walked often; now and then a large one to force
  // growth and out-of-memory answers.
  function automatic logic [14:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 15'($urandom_range(0, 120));
    if (r < 90) return 15'($urandom_range(0, 1100));
    if (r < 97) return 15'($urandom_range(0, 6000));
    return 15'($urandom);
  endfunction

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(99);
    if (live_addrs.size() == 0 || r < 52) begin
      send_item(CMD_ALLOC, pick_size(), 14'($urandom));
    end else if (r < 86) begin
      free_live();
    end else if (r < 93 && retired_addrs.size() != 0) begin
      // Free a block that was freed before: a double free or a stale header.
      send_item(CMD_FREE, 15'($urandom),
                14'(retired_addrs[$urandom_range(retired_addrs.size() - 1)]));
    end else if (r < 97) begin
      // A misaligned offset is ignored; bit 0 set keeps it misaligned.
      send_item(CMD_FREE, 15'($urandom), 14'($urandom) | 14'd1);
    end else begin
      // An offset below one header word is ignored.
      send_item(CMD_FREE, 15'($urandom), 14'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = CMD_ALLOC;
    in_req_size  = '0;
    in_free_addr = '0;
    idle_pct     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Frees before the heap exists are ignored, whatever the offset.
    send_item(CMD_FREE, 15'h7FFF, 14'd8);
    send_item(CMD_FREE, 15'd0, 14'h3FFF);
    // First allocates too large for the region fail and leave the heap
    // uninitialized: the widest size, the top of the range, and the smallest
    // size whose layout passes the region, here by two words.
    send_item(CMD_ALLOC, 15'h7FFF, 14'h3FFF);
    send_item(CMD_ALLOC, 15'd16384, 14'd0);
    send_item(CMD_ALLOC, 15'd8184, 14'd0);
    // A zero-size allocate lays out the initial heap.
    send_item(CMD_ALLOC, 15'd0, 14'd0);
    // Aligned and unaligned sizes, a split and a whole-block take.
    send_item(CMD_ALLOC, 15'd7, 14'd0);
    send_item(CMD_ALLOC, 15'd8, 14'd0);
    send_item(CMD_ALLOC, 15'd900, 14'd0);
    send_item(CMD_ALLOC, 15'd60, 14'd0);
    // A request that needs growth, then one that cannot grow.
    send_item(CMD_ALLOC, 15'd2000, 14'd0);
    send_item(CMD_ALLOC, 15'd16000, 14'd0);
    start <= 1'b0;
    wait_drained();
    // Bad frees: below one word, misaligned.
    send_item(CMD_FREE, 15'd0, 14'd0);
    send_item(CMD_FREE, 15'd0, 14'd7);
    send_item(CMD_FREE, 15'd0, 14'd13);
    // Free neighbors so that a free absorbs the empty blocks after it, then
    // free one block twice.
    while (live_addrs.size() > 2) free_live();
    send_item(CMD_FREE, 15'd0, 14'(retired_addrs[0]));
    // Fragment the heap and then ask for more than any single hole holds, which
    // forces the merge pass before growth.
    send_item(CMD_ALLOC, 15'd3000, 14'd0);
    send_item(CMD_ALLOC, 15'd40, 14'd0);
    start <= 1'b0;
    wait_drained();

    for (int n = 0; n < 1150; n++) begin
      idle_pct = (n < 380) ? 22 : (n < 760) ? 81 : 0;
      random_item();
      maybe_idle();
      // Hold off now and then until every answer is back.
      if (n % 300 == 150) begin
        start <= 1'b0;
        wait_drained();
      end
    end

    start <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Each item may walk the whole heap twice and merge it once; this bound is far
  // above the slowest correct run.
  initial begin
    #400_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/nfha_pkg.sv
sv/nfha_ctrl.sv
sv/nfha_datapath.sv
sv/next_fit_heap_allocator.sv
bench/next_fit_heap_allocator_checker.sv
bench/next_fit_heap_allocator_tb.sv
